FILE: rtl/rk2a_pkg.sv
// Shared types, key codes and character tables for the raw keycode translator.
// No dependencies; used by raw_keycode_to_ascii_core.
package rk2a_pkg;

   typedef logic [6:0] key_code_type;
   typedef logic [7:0] char_type;

   // Key codes
   localparam key_code_type TABLE_LIMIT  = 7'h4b;  // codes below this come from the tables
   localparam key_code_type CURSOR_FIRST = 7'h4c;
   localparam key_code_type CURSOR_LAST  = 7'h4f;
   localparam key_code_type FKEY_FIRST   = 7'h50;
   localparam key_code_type FKEY_LAST    = 7'h59;
   localparam key_code_type HELP_KEY     = 7'h5f;
   localparam key_code_type MOD_FIRST    = 7'h60;
   localparam key_code_type MOD_LAST     = 7'h67;

   // Characters of a two-word sequence: the second words (help, function key base) and the prefix
   localparam char_type HELP_CHAR      = 8'h01;
   localparam char_type FKEY_CHAR_BASE = 8'h3b;
   localparam char_type PREFIX_CHAR    = 8'h00;

   // Modifier flag positions; the low three bits of a modifier code pick the flag
   localparam int MOD_LSHIFT = 0;
   localparam int MOD_RSHIFT = 1;
   localparam int MOD_CAPS   = 2;
   localparam int MOD_CTRL   = 3;
   localparam int MOD_LALT   = 4;
   localparam int MOD_RALT   = 5;
   localparam int MOD_LCMD   = 6;
   localparam int MOD_RCMD   = 7;
   localparam int MOD_COUNT  = 8;

   localparam int MAP_DEPTH = 80;

   localparam char_type PLAIN_MAP [0:MAP_DEPTH-1] = '{
      8'h60, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h5c, 8'h08, 8'h00,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h31, 8'h32, 8'h33,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b,
      8'h6c, 8'h3b, 8'h27, 8'h00, 8'h00, 8'h34, 8'h35, 8'h36,
      8'h00, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e, 8'h6d,
      8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2e, 8'h37, 8'h38, 8'h39,
      8'h20, 8'h08, 8'h09, 8'h0d, 8'h0d, 8'h1b, 8'h7f, 8'h00,
      8'h00, 8'h00, 8'h2d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam char_type SHIFT_MAP [0:MAP_DEPTH-1] = '{
      8'h7e, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26,
      8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h7c, 8'h08, 8'h00,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h31, 8'h32, 8'h33,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b,
      8'h4c, 8'h3a, 8'h22, 8'h00, 8'h00, 8'h34, 8'h35, 8'h36,
      8'h00, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e, 8'h4d,
      8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2e, 8'h37, 8'h38, 8'h39,
      8'h20, 8'h08, 8'h09, 8'h0d, 8'h0d, 8'h1b, 8'h7f, 8'h00,
      8'h00, 8'h00, 8'h2d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // Table lookup; codes past the end of the tables read as zero
   function automatic char_type lookup_char(key_code_type code, logic shifted);
      char_type ch;
      ch = 8'h00;
      if (code < 7'(MAP_DEPTH)) begin
         ch = shifted ? SHIFT_MAP[code] : PLAIN_MAP[code];
      end
      return ch;
   endfunction

   // Cursor keys: down, up, right, left
   function automatic char_type cursor_char(logic [1:0] idx);
      char_type ch;
      case (idx)
         2'd0: ch = 8'h50;
         2'd1: ch = 8'h48;
         2'd2: ch = 8'h4d;
         2'd3: ch = 8'h4b;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/raw_keycode_to_ascii_core.sv
// Raw keyboard byte to ASCII translator with modifier tracking.
// Input words pass through the input register, then the result register.
// Throughput: one input word per cycle for single-result keys while rsp_ready is high;
// help (press or release), function/cursor presses: prefix 0, then code; input waits.
// Reset (synchronous, active high) clears all modifier flags and valid/pending bits.
// Depends on rk2a_pkg.
module raw_keycode_to_ascii_core (
   input  logic       clock,
   input  logic       reset,
   // input word
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_raw_code,
   // result word
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_char_valid,
   output logic [7:0] rsp_char_code,
   output logic       rsp_last,
   output logic       rsp_shift_held,
   output logic       rsp_alt_held,
   output logic       rsp_ctrl_held,
   output logic       rsp_caps_on,
   output logic [1:0] rsp_command_held
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_raw_ff,   in_raw_in;

   // Modifier flags, indexed by the low bits of the modifier key codes
   logic [rk2a_pkg::MOD_COUNT-1:0] mods_ff, mods_in;

   // Second word of a two-word sequence waiting behind the result register
   logic                pend_ff, pend_in;
   rk2a_pkg::char_type  spec_ff, spec_in;

   // Result register
   logic               rsp_valid_ff,  rsp_valid_in;
   logic               char_valid_ff, char_valid_in;
   rk2a_pkg::char_type char_code_ff,  char_code_in;
   logic               last_ff,       last_in;
   logic               shift_ff,      shift_in;
   logic               alt_ff,        alt_in;
   logic               ctrl_ff,       ctrl_in;
   logic               caps_ff,       caps_in;
   logic [1:0]         cmd_ff,        cmd_in;

   // Decode of the word in the input register
   rk2a_pkg::key_code_type         code;
   logic                           press;
   logic                           is_table;
   logic                           is_mod;
   logic                           special;
   rk2a_pkg::char_type             spec_char;
   logic                           shifted;
   logic [rk2a_pkg::MOD_COUNT-1:0] cand_mods;

   // Handshake steering
   logic out_free;
   logic take_first;
   logic take_second;

   always_comb begin
      code    = in_raw_ff[6:0];
      press   = ~in_raw_ff[7];
      shifted = mods_ff[rk2a_pkg::MOD_CAPS] | mods_ff[rk2a_pkg::MOD_LSHIFT]
              | mods_ff[rk2a_pkg::MOD_RSHIFT];

      // Codes 0x70..0x7f and unassigned codes fall through every test below
      // and give a single empty word.
      is_table  = (code < rk2a_pkg::TABLE_LIMIT);
      is_mod    = (code inside {[rk2a_pkg::MOD_FIRST:rk2a_pkg::MOD_LAST]});
      special   = 1'b0;
      spec_char = rk2a_pkg::HELP_CHAR;
      if (code == rk2a_pkg::HELP_KEY) begin
         // help sends its pair on release too
         special   = 1'b1;
         spec_char = rk2a_pkg::HELP_CHAR;
      end else if (press && (code inside {[rk2a_pkg::FKEY_FIRST:rk2a_pkg::FKEY_LAST]})) begin
         special   = 1'b1;
         spec_char = 8'(rk2a_pkg::FKEY_CHAR_BASE + 8'({1'b0, code} - {1'b0, rk2a_pkg::FKEY_FIRST}));
      end else if (press
                   && (code inside {[rk2a_pkg::CURSOR_FIRST:rk2a_pkg::CURSOR_LAST]})) begin
         special   = 1'b1;
         spec_char = rk2a_pkg::cursor_char(code[1:0]);
      end

      // Press sets the modifier flag, release clears it
      cand_mods = mods_ff;
      if (is_mod) begin
         cand_mods[code[2:0]] = press;
      end

      // Send the pending second word first; otherwise move the input word on
      out_free    = ~rsp_valid_ff | rsp_ready;
      take_second = out_free & pend_ff;
      take_first  = out_free & ~pend_ff & in_valid_ff;

      // Input register: refill in the same cycle the held word moves on
      req_ready   = ~in_valid_ff | take_first;
      in_valid_in = in_valid_ff;
      in_raw_in   = in_raw_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_raw_in   = req_raw_code;
      end else if (take_first) begin
         in_valid_in = 1'b0;
      end

      // Result register defaults: hold
      mods_in       = mods_ff;
      pend_in       = pend_ff;
      spec_in       = spec_ff;
      rsp_valid_in  = rsp_valid_ff;
      char_valid_in = char_valid_ff;
      char_code_in  = char_code_ff;
      last_in       = last_ff;
      shift_in      = shift_ff;
      alt_in        = alt_ff;
      ctrl_in       = ctrl_ff;
      caps_in       = caps_ff;
      cmd_in        = cmd_ff;

      if (take_second) begin
         // Special keys leave the flags alone, so the flag fields stay as loaded
         rsp_valid_in  = 1'b1;
         char_valid_in = 1'b1;
         char_code_in  = spec_ff;
         last_in       = 1'b1;
         pend_in       = 1'b0;
      end else if (take_first) begin
         rsp_valid_in  = 1'b1;
         mods_in       = cand_mods;
         pend_in       = special;
         spec_in       = spec_char;
         last_in       = ~special;
         if (is_table) begin
            char_valid_in = press;
            char_code_in  = press ? rk2a_pkg::lookup_char(code, shifted)
                                  : rk2a_pkg::PREFIX_CHAR;
         end else begin
            char_valid_in = special;
            char_code_in  = rk2a_pkg::PREFIX_CHAR;
         end
         shift_in = cand_mods[rk2a_pkg::MOD_LSHIFT] | cand_mods[rk2a_pkg::MOD_RSHIFT];
         alt_in   = cand_mods[rk2a_pkg::MOD_LALT] | cand_mods[rk2a_pkg::MOD_RALT];
         ctrl_in  = cand_mods[rk2a_pkg::MOD_CTRL];
         caps_in  = cand_mods[rk2a_pkg::MOD_CAPS];
         cmd_in   = {cand_mods[rk2a_pkg::MOD_RCMD], cand_mods[rk2a_pkg::MOD_LCMD]};
      end else if (rsp_ready) begin
         // drop the delivered word
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mods_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mods_ff      <= mods_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_raw_ff     <= in_raw_in;
      spec_ff       <= spec_in;
      char_valid_ff <= char_valid_in;
      char_code_ff  <= char_code_in;
      last_ff       <= last_in;
      shift_ff      <= shift_in;
      alt_ff        <= alt_in;
      ctrl_ff       <= ctrl_in;
      caps_ff       <= caps_in;
      cmd_ff        <= cmd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_valid   = char_valid_ff;
   assign rsp_char_code    = char_code_ff;
   assign rsp_last         = last_ff;
   assign rsp_shift_held   = shift_ff;
   assign rsp_alt_held     = alt_ff;
   assign rsp_ctrl_held    = ctrl_ff;
   assign rsp_caps_on      = caps_ff;
   assign rsp_command_held = cmd_ff;

endmodule
